// ===== design/pjq_pkg.sv =====
// shared types and constants for the priority job queue
// no dependencies; imported by pjq_slot_mem and priority_job_queue_tie_order
`default_nettype none

package pjq_pkg;

    // default sizing
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_PRIO_BITS   = 8;

    // fixed field widths
    localparam int TAG_BITS      = 8;
    localparam int PRIO_IN_BITS  = 8;
    localparam int STATUS_BITS   = 2;

    // request codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    // result codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== design/pjq_slot_mem.sv =====
// slot storage: one write port, one read port, registered read data
// depends on pjq_pkg for default sizing
`default_nettype none

module pjq_slot_mem #(
    parameter int DEPTH = pjq_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = pjq_pkg::DEF_PRIO_BITS + pjq_pkg::TAG_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    import pjq_pkg::*;

    logic [WIDTH-1:0] slot_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_array[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/priority_job_queue_tie_order.sv =====
// bounded job queue sorted by ascending priority, with fifo or lifo order among equals
// depends on pjq_pkg and pjq_slot_mem
//
// Jobs are kept sorted in a single-port-read slot memory, head at slot 0. Every
// request gives exactly one result. An insert into a queue holding N jobs walks
// from the tail toward the head, moving one slot up per cycle until it finds its
// place. An insert into an empty queue writes slot 0 directly. A pop reads the
// head and shifts the remaining N-1 jobs down. A full insert or an empty pop only
// reports its status. A result that finds the output register still holding an
// unread result waits until that register is free. A finished result waits in an
// output register, so the next request is taken while it is still unread. The
// user must write the tie_order register (cfg_data) only while the queue is idle;
// the block itself does not enforce it.
`default_nettype none

module priority_job_queue_tie_order #(
    parameter int QUEUE_DEPTH = pjq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIO_BITS   = pjq_pkg::DEF_PRIO_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,
    // requests
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              action,
    input  wire logic [pjq_pkg::PRIO_IN_BITS-1:0]  priority_req,
    input  wire logic [pjq_pkg::TAG_BITS-1:0]      job_tag,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pjq_pkg::status_t                       status,
    output logic      [pjq_pkg::TAG_BITS-1:0]      out_tag,
    output logic      [pjq_pkg::PRIO_IN_BITS-1:0]  out_priority,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]  occupancy
);
    import pjq_pkg::*;

    localparam int IDX_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int SPB        = (PRIO_BITS < PRIO_IN_BITS) ? PRIO_BITS : PRIO_IN_BITS;
    localparam int ENTRY_BITS = SPB + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_HEAD,
        S_POP_HEAD,
        S_POP_SHIFT,
        S_RESULT
    } state_t;

    state_t                  state_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic                    tie_order_reg;
    logic [SPB-1:0]          prio_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    status_t                 res_status_reg;
    logic [TAG_BITS-1:0]     res_tag_reg;
    logic [SPB-1:0]          res_prio_reg;

    logic                    out_valid_reg;
    status_t                 status_reg;
    logic [TAG_BITS-1:0]     out_tag_reg;
    logic [PRIO_IN_BITS-1:0] out_prio_reg;
    logic [CNT_BITS-1:0]     occupancy_reg;

    logic                    wr_en;
    logic [IDX_BITS-1:0]     wr_addr;
    logic [ENTRY_BITS-1:0]   wr_data;
    logic                    rd_en;
    logic [IDX_BITS-1:0]     rd_addr;
    logic [ENTRY_BITS-1:0]   rd_data;

    logic                    in_xfer;
    logic                    out_free;
    logic                    q_empty;
    logic                    q_full;
    logic [SPB-1:0]          in_prio;
    logic [SPB-1:0]          rd_prio;
    logic [TAG_BITS-1:0]     rd_tag;
    logic                    slot_moves;
    logic                    idx_zero;
    logic                    idx_last;
    logic [IDX_BITS-1:0]     idx_up;
    logic [IDX_BITS-1:0]     idx_down;
    logic [IDX_BITS-1:0]     tail_idx;

    pjq_slot_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and helper terms
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign in_prio   = priority_req[SPB-1:0];
    assign rd_prio   = rd_data[TAG_BITS +: SPB];
    assign rd_tag    = rd_data[TAG_BITS-1:0];
    assign idx_zero  = (idx_reg == '0);
    assign idx_last  = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == count_reg);
    assign idx_up    = IDX_BITS'(idx_reg + 1'b1);
    assign idx_down  = IDX_BITS'(idx_reg - 1'b1);
    assign tail_idx  = IDX_BITS'(count_reg - 1'b1);

    // an examined slot moves up when the new job belongs ahead of it
    assign slot_moves = tie_order_reg ? (rd_prio >= prio_reg) : (rd_prio > prio_reg);

    // slot memory access per walk step
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {prio_reg, tag_reg};
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && action == ACT_INSERT && q_empty)
                begin
                    wr_en   = 1'b1;
                    wr_data = {in_prio, job_tag};
                end
                else if (in_xfer && action == ACT_INSERT && !q_full)
                begin
                    rd_en   = 1'b1;
                    rd_addr = tail_idx;
                end
                else if (in_xfer && action == ACT_POP && !q_empty)
                begin
                    rd_en = 1'b1;
                end
            end
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_up;
                if (slot_moves)
                begin
                    wr_data = rd_data;
                    rd_en   = !idx_zero;
                    rd_addr = idx_down;
                end
            end
            S_INS_HEAD:
            begin
                wr_en = 1'b1;
            end
            S_POP_HEAD:
            begin
                rd_en   = (count_reg != CNT_BITS'(1));
                rd_addr = IDX_BITS'(1);
            end
            S_POP_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_down;
                wr_data = rd_data;
                rd_en   = !idx_last;
                rd_addr = idx_up;
            end
            S_RESULT:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // sequencer, count, config and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            tie_order_reg  <= 1'b0;
            res_status_reg <= ST_INSERTED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // config write
            if (cfg_valid && cfg_ready)
            begin
                tie_order_reg <= cfg_data;
            end

            // result transfer; a waiting result reloads the register itself
            if (out_valid_reg && out_ready && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        prio_reg     <= in_prio;
                        tag_reg      <= job_tag;
                        res_tag_reg  <= '0;
                        res_prio_reg <= '0;
                        idx_reg      <= '0;
                        if (action == ACT_INSERT)
                        begin
                            if (q_full)
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_RESULT;
                            end
                            else if (q_empty)
                            begin
                                res_status_reg <= ST_INSERTED;
                                count_reg      <= CNT_BITS'(1);
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                res_status_reg <= ST_INSERTED;
                                idx_reg        <= tail_idx;
                                state_reg      <= S_INS;
                            end
                        end
                        else
                        begin
                            if (q_empty)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                res_status_reg <= ST_POPPED;
                                state_reg      <= S_POP_HEAD;
                            end
                        end
                    end
                end
                S_INS:
                begin
                    if (!slot_moves)
                    begin
                        count_reg <= CNT_BITS'(count_reg + 1'b1);
                        state_reg <= S_RESULT;
                    end
                    else if (idx_zero)
                    begin
                        state_reg <= S_INS_HEAD;
                    end
                    else
                    begin
                        idx_reg <= idx_down;
                    end
                end
                S_INS_HEAD:
                begin
                    count_reg <= CNT_BITS'(count_reg + 1'b1);
                    state_reg <= S_RESULT;
                end
                S_POP_HEAD:
                begin
                    res_tag_reg  <= rd_tag;
                    res_prio_reg <= rd_prio;
                    if (count_reg == CNT_BITS'(1))
                    begin
                        count_reg <= '0;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= IDX_BITS'(1);
                        state_reg <= S_POP_SHIFT;
                    end
                end
                S_POP_SHIFT:
                begin
                    if (idx_last)
                    begin
                        count_reg <= CNT_BITS'(count_reg - 1'b1);
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_up;
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        out_tag_reg   <= res_tag_reg;
                        out_prio_reg  <= PRIO_IN_BITS'(res_prio_reg);
                        occupancy_reg <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = occupancy_reg;

    // occupancy never passes the slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("job count above queue depth");

    // a walk step never reads the slot it writes
    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("slot read and written in the same cycle");

    // a pop of an empty queue reports empty and leaves the count alone
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && action == ACT_POP && q_empty)
        |=> (res_status_reg == ST_EMPTY && count_reg == '0))
        else $error("empty pop mishandled");

    // a loaded result carries the count left by its request
    a_occ_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free)
        |=> (out_valid_reg && occupancy_reg == $past(count_reg)))
        else $error("result occupancy mismatch");

    // the count moves by at most one per request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg))
        |-> (count_reg == CNT_BITS'($past(count_reg) + 1'b1)
            || CNT_BITS'(count_reg + 1'b1) == $past(count_reg)))
        else $error("job count jumped");

endmodule

`default_nettype wire
